### design/midpoint_ellipse_generator_unit_macros.svh
// assertion macros for the midpoint ellipse generator checker
// no dependencies; taken in by the checker file
`ifndef MIDPOINT_ELLIPSE_GENERATOR_UNIT_MACROS_SVH
`define MIDPOINT_ELLIPSE_GENERATOR_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define MEG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define MEG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/meg_pkg.sv
// shared types and constants of the midpoint ellipse generator
// no dependencies; used by controller, datapath and top level
`default_nettype none

package meg_pkg;

  // width of every coordinate on the result transfer
  localparam int OUT_W = 12;

  // operation codes on the input transfer
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // datapath micro-operations issued by the controller
  typedef enum logic [3:0] {
    UOP_NONE      = 4'd0,
    UOP_LOAD      = 4'd1,
    UOP_SQ_RX     = 4'd2,
    UOP_SQ_RY     = 4'd3,
    UOP_INIT_DY   = 4'd4,
    UOP_INIT_DEC  = 4'd5,
    UOP_R2_TX     = 4'd6,
    UOP_R2_RY     = 4'd7,
    UOP_R2_TY     = 4'd8,
    UOP_R2_RX     = 4'd9,
    UOP_R2_PROD   = 4'd10,
    UOP_R2_FIN    = 4'd11,
    UOP_STEP      = 4'd12,
    UOP_EMIT_ZERO = 4'd13
  } uop_e;

  typedef struct packed {
    uop_e uop;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic need_region_two;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

### design/meg_datapath.sv
// datapath: walker registers, shared multiplier, decision update, result register
// depends on meg_pkg
`default_nettype none

module meg_datapath #(
  parameter int COORD_BITS  = 10,
  parameter int RADIUS_BITS = 9
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  meg_pkg::cmd_t                    cmd_i,
  input  wire        [COORD_BITS-1:0]      center_x_i,
  input  wire        [COORD_BITS-1:0]      center_y_i,
  input  wire        [RADIUS_BITS-1:0]     radius_x_i,
  input  wire        [RADIUS_BITS-1:0]     radius_y_i,
  input  wire                              m_ready_i,
  output meg_pkg::status_t                 status_o,
  output logic                             out_valid_o,
  output logic                             point_valid_o,
  output logic signed [meg_pkg::OUT_W-1:0] right_x_o,
  output logic signed [meg_pkg::OUT_W-1:0] left_x_o,
  output logic signed [meg_pkg::OUT_W-1:0] lower_y_o,
  output logic signed [meg_pkg::OUT_W-1:0] upper_y_o,
  output logic                             in_region_two_o,
  output logic                             last_group_o
);

  localparam int OFS_W = RADIUS_BITS + 2;
  localparam int SQ_W  = 2 * RADIUS_BITS;
  localparam int MA_W  = 2 * RADIUS_BITS + 6;
  localparam int P_W   = MA_W + SQ_W;
  localparam int DEC_W = P_W;
  localparam int SLP_W = 3 * RADIUS_BITS + 4;
  localparam int CO_W  = (COORD_BITS > OFS_W) ? COORD_BITS : OFS_W;
  localparam int SUM_W = ((CO_W > meg_pkg::OUT_W) ? CO_W : meg_pkg::OUT_W) + 1;

  logic        [COORD_BITS-1:0]  cx_q, cx_d, cy_q, cy_d;
  logic        [RADIUS_BITS-1:0] rx_q, rx_d, ry_q, ry_d;
  logic        [SQ_W-1:0]        rx_sq_q, rx_sq_d, ry_sq_q, ry_sq_d;
  logic        [OFS_W-1:0]       ofs_x_q, ofs_x_d, ofs_y_q, ofs_y_d;
  logic signed [SLP_W-1:0]       sdx_q, sdx_d, sdy_q, sdy_d;
  logic signed [DEC_W-1:0]       dec_q, dec_d;
  logic        [P_W-1:0]         p_q, p_d;
  logic                          busy_q, busy_d, region_q, region_d;
  logic                          out_valid_q, out_valid_d;
  logic                          pv_q, pv_d, r2_q, r2_d, last_q, last_d;
  logic signed [meg_pkg::OUT_W-1:0] rx_out_q, rx_out_d, lx_out_q, lx_out_d;
  logic signed [meg_pkg::OUT_W-1:0] ly_out_q, ly_out_d, uy_out_q, uy_out_d;

  logic        [MA_W-1:0]        mul_a;
  logic        [SQ_W-1:0]        mul_b;
  logic        [P_W-1:0]         prod;
  logic        [OFS_W:0]         tx;
  logic        [OFS_W-1:0]       aty;
  logic signed [DEC_W-1:0]       p4, p_s, rx_sq_s, ry_sq_s, sx, sy, step_term;
  logic signed [SLP_W-1:0]       two_rx_sq, two_ry_sq, sdx_n, sdy_n, p2;
  logic        [SUM_W-1:0]       cx_ext, cy_ext, ox_ext, oy_ext;
  logic        [SUM_W-1:0]       right_full, left_full, lower_full, upper_full;

  // operands the multiplier and the decision update draw from
  assign tx        = {ofs_x_q, 1'b1};
  assign aty       = (ofs_y_q == '0) ? OFS_W'(1) : ofs_y_q - OFS_W'(1);
  assign prod      = mul_a * mul_b;
  assign p_s       = $signed(p_q);
  assign p4        = $signed({p_q[P_W-3:0], 2'b00});
  assign p2        = $signed({p_q[SLP_W-2:0], 1'b0});
  assign rx_sq_s   = $signed({{(DEC_W-SQ_W){1'b0}}, rx_sq_q});
  assign ry_sq_s   = $signed({{(DEC_W-SQ_W){1'b0}}, ry_sq_q});
  assign two_rx_sq = $signed({{(SLP_W-SQ_W-1){1'b0}}, rx_sq_q, 1'b0});
  assign two_ry_sq = $signed({{(SLP_W-SQ_W-1){1'b0}}, ry_sq_q, 1'b0});
  assign sdx_n     = sdx_q + two_ry_sq;
  assign sdy_n     = sdy_q - two_rx_sq;
  assign sx        = $signed({{(DEC_W-SLP_W){sdx_n[SLP_W-1]}}, sdx_n});
  assign sy        = $signed({{(DEC_W-SLP_W){sdy_n[SLP_W-1]}}, sdy_n});

  assign cx_ext     = {{(SUM_W-COORD_BITS){1'b0}}, cx_q};
  assign cy_ext     = {{(SUM_W-COORD_BITS){1'b0}}, cy_q};
  assign ox_ext     = {{(SUM_W-OFS_W){1'b0}}, ofs_x_q};
  assign oy_ext     = {{(SUM_W-OFS_W){1'b0}}, ofs_y_q};
  assign right_full = cx_ext + ox_ext;
  assign left_full  = cx_ext - ox_ext;
  assign lower_full = cy_ext + oy_ext;
  assign upper_full = cy_ext - oy_ext;

  always_comb begin
    cx_d = cx_q;  cy_d = cy_q;  rx_d = rx_q;  ry_d = ry_q;
    rx_sq_d = rx_sq_q;  ry_sq_d = ry_sq_q;
    ofs_x_d = ofs_x_q;  ofs_y_d = ofs_y_q;
    sdx_d = sdx_q;  sdy_d = sdy_q;  dec_d = dec_q;  p_d = p_q;
    busy_d = busy_q;  region_d = region_q;
    pv_d = pv_q;  r2_d = r2_q;  last_d = last_q;
    rx_out_d = rx_out_q;  lx_out_d = lx_out_q;
    ly_out_d = ly_out_q;  uy_out_d = uy_out_q;
    mul_a = '0;
    mul_b = '0;
    step_term = '0;
    out_valid_d = out_valid_q && !m_ready_i;

    unique case (cmd_i.uop)
      meg_pkg::UOP_NONE: begin
      end
      meg_pkg::UOP_LOAD: begin
        cx_d     = center_x_i;
        cy_d     = center_y_i;
        rx_d     = radius_x_i;
        ry_d     = radius_y_i;
        ofs_x_d  = '0;
        ofs_y_d  = {{(OFS_W-RADIUS_BITS){1'b0}}, radius_y_i};
        sdx_d    = '0;
        region_d = 1'b0;
        busy_d   = 1'b1;
      end
      meg_pkg::UOP_SQ_RX: begin
        mul_a = {{(MA_W-RADIUS_BITS){1'b0}}, rx_q};
        mul_b = {{(SQ_W-RADIUS_BITS){1'b0}}, rx_q};
        p_d   = prod;
      end
      meg_pkg::UOP_SQ_RY: begin
        rx_sq_d = p_q[SQ_W-1:0];
        mul_a   = {{(MA_W-RADIUS_BITS){1'b0}}, ry_q};
        mul_b   = {{(SQ_W-RADIUS_BITS){1'b0}}, ry_q};
        p_d     = prod;
      end
      meg_pkg::UOP_INIT_DY: begin
        // 4*ry^2 + rx^2, then rx^2*ry for the slope and the last term
        ry_sq_d = p_q[SQ_W-1:0];
        dec_d   = p4 + rx_sq_s;
        mul_a   = {{(MA_W-SQ_W){1'b0}}, rx_sq_q};
        mul_b   = {{(SQ_W-RADIUS_BITS){1'b0}}, ry_q};
        p_d     = prod;
      end
      meg_pkg::UOP_INIT_DEC: begin
        sdy_d = p2;
        dec_d = dec_q - p4;
      end
      meg_pkg::UOP_R2_TX: begin
        region_d = 1'b1;
        mul_a    = {{(MA_W-OFS_W-1){1'b0}}, tx};
        mul_b    = {{(SQ_W-OFS_W-1){1'b0}}, tx};
        p_d      = prod;
      end
      meg_pkg::UOP_R2_RY: begin
        mul_a = p_q[MA_W-1:0];
        mul_b = ry_sq_q;
        p_d   = prod;
      end
      meg_pkg::UOP_R2_TY: begin
        dec_d = p_s;
        mul_a = {{(MA_W-OFS_W){1'b0}}, aty};
        mul_b = {{(SQ_W-OFS_W){1'b0}}, aty};
        p_d   = prod;
      end
      meg_pkg::UOP_R2_RX: begin
        mul_a = p_q[MA_W-1:0];
        mul_b = rx_sq_q;
        p_d   = prod;
      end
      meg_pkg::UOP_R2_PROD: begin
        dec_d = dec_q + p4;
        mul_a = {{(MA_W-SQ_W){1'b0}}, rx_sq_q};
        mul_b = ry_sq_q;
        p_d   = prod;
      end
      meg_pkg::UOP_R2_FIN: begin
        dec_d = dec_q - p4;
      end
      meg_pkg::UOP_STEP: begin
        out_valid_d = 1'b1;
        pv_d        = 1'b1;
        rx_out_d    = $signed(right_full[meg_pkg::OUT_W-1:0]);
        lx_out_d    = $signed(left_full[meg_pkg::OUT_W-1:0]);
        ly_out_d    = $signed(lower_full[meg_pkg::OUT_W-1:0]);
        uy_out_d    = $signed(upper_full[meg_pkg::OUT_W-1:0]);
        r2_d        = region_q;
        last_d      = region_q && (ofs_y_q == '0);
        if (!region_q) begin
          ofs_x_d = ofs_x_q + OFS_W'(1);
          sdx_d   = sdx_n;
          if (dec_q[DEC_W-1]) begin
            step_term = sx + ry_sq_s;
          end else begin
            ofs_y_d   = ofs_y_q - OFS_W'(1);
            sdy_d     = sdy_n;
            step_term = sx - sy + ry_sq_s;
          end
          dec_d = dec_q + (step_term <<< 2);
        end else if (ofs_y_q == '0) begin
          busy_d = 1'b0;
        end else begin
          ofs_y_d = ofs_y_q - OFS_W'(1);
          sdy_d   = sdy_n;
          if (!dec_q[DEC_W-1] && (dec_q != '0)) begin
            step_term = rx_sq_s - sy;
          end else begin
            ofs_x_d   = ofs_x_q + OFS_W'(1);
            sdx_d     = sdx_n;
            step_term = sx - sy + rx_sq_s;
          end
          dec_d = dec_q + (step_term <<< 2);
        end
      end
      meg_pkg::UOP_EMIT_ZERO: begin
        out_valid_d = 1'b1;
        pv_d        = 1'b0;
        rx_out_d    = '0;
        lx_out_d    = '0;
        ly_out_d    = '0;
        uy_out_d    = '0;
        r2_d        = 1'b0;
        last_d      = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      region_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      region_q    <= region_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q     <= cx_d;
    cy_q     <= cy_d;
    rx_q     <= rx_d;
    ry_q     <= ry_d;
    rx_sq_q  <= rx_sq_d;
    ry_sq_q  <= ry_sq_d;
    ofs_x_q  <= ofs_x_d;
    ofs_y_q  <= ofs_y_d;
    sdx_q    <= sdx_d;
    sdy_q    <= sdy_d;
    dec_q    <= dec_d;
    p_q      <= p_d;
    pv_q     <= pv_d;
    r2_q     <= r2_d;
    last_q   <= last_d;
    rx_out_q <= rx_out_d;
    lx_out_q <= lx_out_d;
    ly_out_q <= ly_out_d;
    uy_out_q <= uy_out_d;
  end

  assign status_o.busy            = busy_q;
  assign status_o.need_region_two = !region_q && !(sdx_q < sdy_q);
  assign status_o.out_free        = !out_valid_q || m_ready_i;

  assign out_valid_o     = out_valid_q;
  assign point_valid_o   = pv_q;
  assign right_x_o       = rx_out_q;
  assign left_x_o        = lx_out_q;
  assign lower_y_o       = ly_out_q;
  assign upper_y_o       = uy_out_q;
  assign in_region_two_o = r2_q;
  assign last_group_o    = last_q;

endmodule

`default_nettype wire

### design/meg_controller.sv
// controller: sequences start set-up, region change and steps over the datapath
// depends on meg_pkg
`default_nettype none

module meg_controller (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              s_valid_i,
  input  wire              operation_i,
  input  meg_pkg::status_t status_i,
  output logic             s_ready_o,
  output meg_pkg::cmd_t    cmd_o
);

  typedef enum logic [12:0] {
    S_IDLE     = 13'h0001,
    S_SQ_RX    = 13'h0002,
    S_SQ_RY    = 13'h0004,
    S_INIT_DY  = 13'h0008,
    S_INIT_DEC = 13'h0010,
    S_R2_TX    = 13'h0020,
    S_R2_RY    = 13'h0040,
    S_R2_TY    = 13'h0080,
    S_R2_RX    = 13'h0100,
    S_R2_PROD  = 13'h0200,
    S_R2_FIN   = 13'h0400,
    S_STEP     = 13'h0800,
    S_ZERO     = 13'h1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o.uop = meg_pkg::UOP_NONE;
    s_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          if (operation_i == meg_pkg::OP_START) begin
            cmd_o.uop = meg_pkg::UOP_LOAD;
            state_d   = S_SQ_RX;
          end else if (!status_i.busy) begin
            state_d = S_ZERO;
          end else if (status_i.need_region_two) begin
            state_d = S_R2_TX;
          end else begin
            state_d = S_STEP;
          end
        end
      end
      S_SQ_RX: begin
        cmd_o.uop = meg_pkg::UOP_SQ_RX;
        state_d   = S_SQ_RY;
      end
      S_SQ_RY: begin
        cmd_o.uop = meg_pkg::UOP_SQ_RY;
        state_d   = S_INIT_DY;
      end
      S_INIT_DY: begin
        cmd_o.uop = meg_pkg::UOP_INIT_DY;
        state_d   = S_INIT_DEC;
      end
      S_INIT_DEC: begin
        cmd_o.uop = meg_pkg::UOP_INIT_DEC;
        state_d   = S_ZERO;
      end
      S_R2_TX: begin
        cmd_o.uop = meg_pkg::UOP_R2_TX;
        state_d   = S_R2_RY;
      end
      S_R2_RY: begin
        cmd_o.uop = meg_pkg::UOP_R2_RY;
        state_d   = S_R2_TY;
      end
      S_R2_TY: begin
        cmd_o.uop = meg_pkg::UOP_R2_TY;
        state_d   = S_R2_RX;
      end
      S_R2_RX: begin
        cmd_o.uop = meg_pkg::UOP_R2_RX;
        state_d   = S_R2_PROD;
      end
      S_R2_PROD: begin
        cmd_o.uop = meg_pkg::UOP_R2_PROD;
        state_d   = S_R2_FIN;
      end
      S_R2_FIN: begin
        cmd_o.uop = meg_pkg::UOP_R2_FIN;
        state_d   = S_STEP;
      end
      S_STEP: begin
        // wait for room in the result register
        if (status_i.out_free) begin
          cmd_o.uop = meg_pkg::UOP_STEP;
          state_d   = S_IDLE;
        end
      end
      S_ZERO: begin
        if (status_i.out_free) begin
          cmd_o.uop = meg_pkg::UOP_EMIT_ZERO;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### design/midpoint_ellipse_generator_unit.sv
// top level of the midpoint ellipse generator: stream ports, controller and datapath
// depends on meg_pkg, meg_controller, meg_datapath
// usage:
//   slave channel carries commands; tuser is the operation (start or step), tdata the
//   centre and radii, read only on start. every command gives exactly one transfer
//   on the master channel. a start answers with an all-zero result; a step answers
//   with one group of four symmetric points, or all zero when no ellipse is active.
// timing:
//   an ordinary step passes from idle to the step state, which registers its result once
//   the result register has room; a start runs its set-up states, whose three set-up
//   multiplies share the one multiplier, then the zero state. the step that crosses into
//   region two first runs the region-change states building the new decision term.
//   a new command is taken the cycle after the previous result is registered.
// reset:
//   rst_ni clears the controller, the active flag and the result valid; no ellipse
//   is active afterwards.
// stall:
//   the result waits in its register while m_axis_tready is low; the next command
//   may be accepted and worked on, and is held before its result until room appears.
`default_nettype none

module midpoint_ellipse_generator_unit #(
  parameter int COORD_BITS  = 10,
  parameter int RADIUS_BITS = 9
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // command channel
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  // center_x, center_y, radius_x, radius_y, zero padding to whole bytes
  input  wire  [((2*COORD_BITS+2*RADIUS_BITS+7)/8)*8-1:0] s_axis_tdata,
  // operation
  input  wire  [0:0]                   s_axis_tuser,
  // result channel
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  // right_x, left_x, lower_y, upper_y
  output logic [4*meg_pkg::OUT_W-1:0]  m_axis_tdata,
  // point_valid, in_region_two
  output logic [1:0]                   m_axis_tuser,
  // last_group
  output logic                         m_axis_tlast
);

  localparam int CY_LO = COORD_BITS;
  localparam int RX_LO = 2 * COORD_BITS;
  localparam int RY_LO = 2 * COORD_BITS + RADIUS_BITS;

  meg_pkg::cmd_t    cmd;
  meg_pkg::status_t status;

  logic                             point_valid;
  logic                             in_region_two;
  logic signed [meg_pkg::OUT_W-1:0] right_x, left_x, lower_y, upper_y;

  meg_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .operation_i (s_axis_tuser[0]),
    .status_i    (status),
    .s_ready_o   (s_axis_tready),
    .cmd_o       (cmd)
  );

  meg_datapath #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .center_x_i      (s_axis_tdata[COORD_BITS-1:0]),
    .center_y_i      (s_axis_tdata[CY_LO +: COORD_BITS]),
    .radius_x_i      (s_axis_tdata[RX_LO +: RADIUS_BITS]),
    .radius_y_i      (s_axis_tdata[RY_LO +: RADIUS_BITS]),
    .m_ready_i       (m_axis_tready),
    .status_o        (status),
    .out_valid_o     (m_axis_tvalid),
    .point_valid_o   (point_valid),
    .right_x_o       (right_x),
    .left_x_o        (left_x),
    .lower_y_o       (lower_y),
    .upper_y_o       (upper_y),
    .in_region_two_o (in_region_two),
    .last_group_o    (m_axis_tlast)
  );

  // result packing, first field in the lowest bits
  assign m_axis_tdata = {upper_y, lower_y, left_x, right_x};
  assign m_axis_tuser = {in_region_two, point_valid};

endmodule

`default_nettype wire

### design/midpoint_ellipse_generator_unit_checker.sv
// port-level checker for the midpoint ellipse generator, bound to the top level
// depends on midpoint_ellipse_generator_unit_macros.svh
`default_nettype none
`include "midpoint_ellipse_generator_unit_macros.svh"

module midpoint_ellipse_generator_unit_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [47:0] m_axis_tdata,
  input wire [1:0]  m_axis_tuser,
  input wire        m_axis_tlast
);

  // a stalled result holds its contents
  `MEG_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")

  // a result without points is all zero
  `MEG_ASSERT_SAME(a_zero_result, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[0], (m_axis_tdata == 48'd0) && !m_axis_tuser[1] && !m_axis_tlast, "empty result not zero")

  // the closing group is a point group in region two
  `MEG_ASSERT_SAME(a_last_region, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast, m_axis_tuser == 2'b11, "last group outside region two")

  // a command is never taken back to back with another
  `MEG_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "command taken back to back")

endmodule

bind midpoint_ellipse_generator_unit midpoint_ellipse_generator_unit_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

### verif/midpoint_ellipse_generator_unit_tb.sv
// self-checking testbench for midpoint_ellipse_generator_unit: directed and random commands
// with an in-bench ellipse walker predicting every result transfer
// depends on meg_pkg and the midpoint_ellipse_generator_unit rtl
`timescale 1ns / 100ps

module midpoint_ellipse_generator_unit_tb;

  localparam int CMD_W       = ((2*10 + 2*9 + 7) / 8) * 8;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 20;

  typedef struct packed {
    logic       op;
    logic [9:0] cx;
    logic [9:0] cy;
    logic [8:0] rx;
    logic [8:0] ry;
  } ellipse_cmd_t;

  typedef struct packed {
    logic                      point_valid;
    logic [meg_pkg::OUT_W-1:0] right_x;
    logic [meg_pkg::OUT_W-1:0] left_x;
    logic [meg_pkg::OUT_W-1:0] lower_y;
    logic [meg_pkg::OUT_W-1:0] upper_y;
    logic                      in_region_two;
    logic                      last_group;
  } point_group_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [CMD_W-1:0] s_axis_tdata = '0;
  logic [0:0]       s_axis_tuser = meg_pkg::OP_STEP;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [4*meg_pkg::OUT_W-1:0] m_axis_tdata;
  logic [1:0]       m_axis_tuser;
  logic             m_axis_tlast;

  midpoint_ellipse_generator_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 20 ns period
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // commands waiting to be driven, and point groups waiting to come out
  ellipse_cmd_t cmds_pending[$];
  point_group_t groups_due[$];
  ellipse_cmd_t cmd_on_bus;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  int mismatch_count = 0;
  int starts_sent = 0;
  int steps_sent = 0;
  int groups_checked = 0;
  int ellipses_done = 0;
  int region_two_groups = 0;
  int stall_cycles = 0;

  // walker state of the predictor, kept wide so the scaled terms never wrap
  logic   walk_active = 1'b0;
  logic   walk_in_r2 = 1'b0;
  longint walk_x = 0;
  longint walk_y = 0;
  longint grad_x = 0;      // 2*ry^2*x
  longint grad_y = 0;      // 2*rx^2*y
  longint decision = 0;    // decision term times four
  longint ctr_x = 0;
  longint ctr_y = 0;
  longint rx_sq = 0;
  longint ry_sq = 0;

  // advance the walker by one command and give the result it causes
  function automatic point_group_t trace_ellipse_step(ellipse_cmd_t c);
    point_group_t g;
    longint tx;
    longint ty;
    g = '0;
    if (c.op == meg_pkg::OP_START) begin
      ctr_x       = longint'(c.cx);
      ctr_y       = longint'(c.cy);
      rx_sq       = longint'(c.rx) * longint'(c.rx);
      ry_sq       = longint'(c.ry) * longint'(c.ry);
      walk_x      = 0;
      walk_y      = longint'(c.ry);
      grad_x      = 0;
      grad_y      = 2 * rx_sq * walk_y;
      decision    = 4 * ry_sq - 4 * rx_sq * walk_y + rx_sq;
      walk_in_r2  = 1'b0;
      walk_active = 1'b1;
      return g;
    end
    // a step with no ellipse in progress answers all zero
    if (!walk_active) return g;

    // region change: new decision term from the current point, group still emitted
    if (!walk_in_r2 && !(grad_x < grad_y)) begin
      tx         = 2 * walk_x + 1;
      ty         = walk_y - 1;
      walk_in_r2 = 1'b1;
      decision   = ry_sq * tx * tx + 4 * rx_sq * ty * ty - 4 * rx_sq * ry_sq;
    end

    g.point_valid   = 1'b1;
    g.right_x       = meg_pkg::OUT_W'(ctr_x + walk_x);
    g.left_x        = meg_pkg::OUT_W'(ctr_x - walk_x);
    g.lower_y       = meg_pkg::OUT_W'(ctr_y + walk_y);
    g.upper_y       = meg_pkg::OUT_W'(ctr_y - walk_y);
    g.in_region_two = walk_in_r2;

    if (!walk_in_r2) begin
      walk_x = walk_x + 1;
      grad_x = grad_x + 2 * ry_sq;
      if (decision < 0) begin
        decision = decision + 4 * (grad_x + ry_sq);
      end else begin
        walk_y   = walk_y - 1;
        grad_y   = grad_y - 2 * rx_sq;
        decision = decision + 4 * (grad_x - grad_y + ry_sq);
      end
    end else if (walk_y == 0) begin
      g.last_group = 1'b1;
      walk_active  = 1'b0;
    end else begin
      walk_y = walk_y - 1;
      grad_y = grad_y - 2 * rx_sq;
      if (decision > 0) begin
        decision = decision + 4 * (rx_sq - grad_y);
      end else begin
        walk_x   = walk_x + 1;
        grad_x   = grad_x + 2 * ry_sq;
        decision = decision + 4 * (grad_x - grad_y + rx_sq);
      end
    end
    return g;
  endfunction

  task automatic push_cmd(logic op, int cx, int cy, int rx, int ry);
    ellipse_cmd_t c;
    c.op = op;
    c.cx = 10'(cx);
    c.cy = 10'(cy);
    c.rx = 9'(rx);
    c.ry = 9'(ry);
    cmds_pending.push_back(c);
  endtask

  // steps carry random payload, which the block must ignore
  task automatic push_step();
    push_cmd(meg_pkg::OP_STEP, $urandom_range(1023), $urandom_range(1023),
             $urandom_range(511), $urandom_range(511));
  endtask

  task automatic report_field(string name, logic [meg_pkg::OUT_W-1:0] want,
                              logic [meg_pkg::OUT_W-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected 0x%03h, got 0x%03h", $time, name, want, got);
    end
  endtask

  // --------------------------------------------------------------------------
  // driver: one command transfer per handshake; prediction made at acceptance
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= meg_pkg::OP_STEP;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        groups_due.push_back(trace_ellipse_step(cmd_on_bus));
        if (cmd_on_bus.op == meg_pkg::OP_START) starts_sent++;
        else steps_sent++;
      end
      // load the next command only once the bus is free
      if (!s_axis_tvalid || s_axis_tready) begin
        if (cmds_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd_on_bus = cmds_pending.pop_front();
          s_axis_tvalid <= 1'b1;
          // padding bits stay zero
          s_axis_tdata  <= {{(CMD_W-38){1'b0}}, cmd_on_bus.ry, cmd_on_bus.rx,
                            cmd_on_bus.cy, cmd_on_bus.cx};
          s_axis_tuser  <= cmd_on_bus.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // monitor: every result transfer is checked against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    point_group_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (groups_due.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result transfer, expected none, got tdata 0x%012h tuser %b",
                 $time, m_axis_tdata, m_axis_tuser);
      end else begin
        want = groups_due.pop_front();
        report_field("point_valid", meg_pkg::OUT_W'(want.point_valid),
                     meg_pkg::OUT_W'(m_axis_tuser[0]));
        report_field("right_x", want.right_x, m_axis_tdata[meg_pkg::OUT_W-1:0]);
        report_field("left_x", want.left_x,
                     m_axis_tdata[2*meg_pkg::OUT_W-1:meg_pkg::OUT_W]);
        report_field("lower_y", want.lower_y,
                     m_axis_tdata[3*meg_pkg::OUT_W-1:2*meg_pkg::OUT_W]);
        report_field("upper_y", want.upper_y,
                     m_axis_tdata[4*meg_pkg::OUT_W-1:3*meg_pkg::OUT_W]);
        report_field("in_region_two", meg_pkg::OUT_W'(want.in_region_two),
                     meg_pkg::OUT_W'(m_axis_tuser[1]));
        report_field("last_group", meg_pkg::OUT_W'(want.last_group),
                     meg_pkg::OUT_W'(m_axis_tlast));
        groups_checked++;
        if (want.last_group) ellipses_done++;
        if (want.point_valid && want.in_region_two) region_two_groups++;
      end
    end
  end

  // watchdog: cycles with work outstanding but no transfer on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cmds_pending.size() == 0 && !s_axis_tvalid && groups_due.size() == 0)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, stall_cycles, groups_due.size());
        $display("midpoint_ellipse_generator_unit test failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // hold off until every command is sent and every result has come back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (cmds_pending.size() != 0 || s_axis_tvalid || groups_due.size() != 0);
  endtask

  // well-formed ellipses with random content, plus some noise and cut-short runs
  task automatic run_phase(int idle_pct, int stall_pct, int n_items);
    int added;
    int rx;
    int ry;
    int n_steps;
    int pick;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    added = 0;
    while (added < n_items) begin
      pick = $urandom_range(99);
      if (pick < 82) begin
        pick = $urandom_range(99);
        if (pick < 90) begin
          rx = $urandom_range(12);
          ry = $urandom_range(12);
        end else if (pick < 98) begin
          rx = $urandom_range(60);
          ry = $urandom_range(60);
        end else begin
          rx = $urandom_range(200);
          ry = $urandom_range(200);
        end
        push_cmd(meg_pkg::OP_START, $urandom_range(1023), $urandom_range(1023), rx, ry);
        // enough steps to finish, any left over answered as idle steps
        n_steps = rx + ry + 1 + $urandom_range(1);
        // now and then a fresh start cuts the ellipse short
        if ($urandom_range(9) == 0) n_steps = $urandom_range(n_steps);
        repeat (n_steps) push_step();
        added += n_steps + 1;
      end else begin
        repeat ($urandom_range(3, 1)) begin
          push_cmd(1'($urandom_range(1)), $urandom_range(1023), $urandom_range(1023),
                   $urandom_range(511), $urandom_range(511));
          added++;
        end
      end
    end
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // zero radii at the origin: one group at y = 0, then a step with nothing active
    push_cmd(meg_pkg::OP_START, 0, 0, 0, 0);
    push_step();
    push_step();
    // widest ellipse at the far corner, cut short by a new start
    push_cmd(meg_pkg::OP_START, 1023, 1023, 511, 511);
    repeat (4) push_step();
    // zero horizontal radius: vertical run, lower rows run past the top coordinate
    push_cmd(meg_pkg::OP_START, 0, 1023, 0, 3);
    repeat (5) push_step();
    // zero vertical radius
    push_cmd(meg_pkg::OP_START, 1023, 0, 3, 0);
    push_step();
    // small ellipse that crosses from region one to region two
    push_cmd(meg_pkg::OP_START, 5, 7, 2, 1);
    repeat (4) push_step();
    run_phase(0, 0, 0);

    // the drain at the end of each phase also pauses the sender until all results are back
    run_phase(0, 0, 325);
    run_phase(67, 0, 325);
    run_phase(0, 67, 325);
    run_phase(27, 27, 325);

    repeat (DRAIN_WAIT) @(negedge clk_i);
    $display("%0d commands accepted (%0d starts, %0d steps), %0d results checked",
             starts_sent + steps_sent, starts_sent, steps_sent, groups_checked);
    $display("%0d ellipses traced to their last group, %0d region-two groups seen",
             ellipses_done, region_two_groups);
    if (mismatch_count == 0 && groups_due.size() == 0) begin
      $display("midpoint_ellipse_generator_unit test passed");
    end else begin
      $display("midpoint_ellipse_generator_unit test failed");
    end
    $finish;
  end

endmodule
